[hdl/spaw_pkg.sv]
// ----------------------------------------------------------------------------
// spaw_pkg
// Shared constants and saturation helpers for the speed PI controller.
// ----------------------------------------------------------------------------
`default_nettype none

package spaw_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned LimW    = 31;
  // working width for pre-saturation sums
  localparam int unsigned WideW   = 46;

  // item modes
  localparam logic [ModeW-1:0] MODE_STEP    = 2'd0;
  localparam logic [ModeW-1:0] MODE_PRELOAD = 2'd1;
  localparam logic [ModeW-1:0] MODE_CLEAR   = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INTEGRAL_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AW_GAIN       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CURRENT_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_PERIOD = 3'd4;

  localparam logic [DataW-1:0] PROP_GAIN_RST     = 32'd0;
  localparam logic [DataW-1:0] INTEGRAL_GAIN_RST = 32'd0;
  localparam logic [DataW-1:0] AW_GAIN_RST       = 32'd0;
  localparam logic [LimW-1:0]  CURRENT_LIMIT_RST = 31'd65536;
  localparam logic [DataW-1:0] SAMPLE_PERIOD_RST = 32'd429497;

  localparam logic signed [WideW-1:0] SatHi = WideW'(32'sh7FFF_FFFF);
  localparam logic signed [WideW-1:0] SatLo = WideW'(32'sh8000_0000);

  // true when x does not fit a signed 32-bit word
  function automatic logic over32(input logic signed [WideW-1:0] x);
    return (x > SatHi) || (x < SatLo);
  endfunction

  // saturate to signed 32 bits
  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] x);
    logic signed [DataW-1:0] r;
    if (x > SatHi) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SatLo) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

  // clamp to the symmetric range -lim..+lim
  function automatic logic signed [DataW-1:0] clamp_lim(input logic signed [WideW-1:0] x,
                                                        input logic [LimW-1:0] lim);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    logic signed [WideW-1:0] r;
    hi = $signed({{(WideW-LimW){1'b0}}, lim});
    lo = -hi;
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r[DataW-1:0];
  endfunction

endpackage

`default_nettype wire

[hdl/speed_pi_back_calc_antiwindup_unit.sv]
// ----------------------------------------------------------------------------
// speed_pi_back_calc_antiwindup_unit
// Fixed-point speed PI controller with current clamping and back-calculation
// anti-windup, built around one shared multiplier.
// ----------------------------------------------------------------------------
// Each request carries a mode and the speed samples. A control step forms the
// saturated speed error, the proportional term (kp Q8.24), the unsaturated
// command with the integrator and the command clamped to +-current_limit,
// then advances the integrator by (ki*error + kaw*(command - raw)) * period,
// rounded half away from zero and clamped to the same limit. Preload sets the
// integrator to preload_current - prop (clamped); clear zeroes it. When the
// error, the proportional term or the raw sum saturates, overflow is set and
// the integrator holds. A control step makes five passes through the single
// registered 33x33 multiplier: kp*err, then ki*err while prop saturates; it
// forms the raw sum, then kaw*diff, combines the partial sums, makes the two
// halves of the period scaling and updates the integrator. Preload stops after
// the proportional term and clear needs no multiply. Every request then loads
// the result register, and the sequencer returns to idle before the next one
// is taken.
// A result waits in the output register; the next request is taken while it
// is still pending. Configuration writes are taken while the sequencer is
// idle; a current_limit write clamps the stored integrator at once, zero
// writes to current_limit or sample_period are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_pi_back_calc_antiwindup_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic        [spaw_pkg::ModeW-1:0]   mode_i,
  input  logic signed [spaw_pkg::DataW-1:0]   speed_target_i,
  input  logic signed [spaw_pkg::DataW-1:0]   speed_measured_i,
  input  logic signed [spaw_pkg::DataW-1:0]   preload_current_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [spaw_pkg::DataW-1:0]   speed_error_o,
  output logic signed [spaw_pkg::DataW-1:0]   prop_term_o,
  output logic signed [spaw_pkg::DataW-1:0]   raw_command_o,
  output logic signed [spaw_pkg::DataW-1:0]   current_command_o,
  output logic                                limited_o,
  output logic signed [spaw_pkg::DataW-1:0]   integrator_out_o,
  output logic                                overflow_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [spaw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic        [spaw_pkg::DataW-1:0]   cfg_data_i
);

  import spaw_pkg::*;

  localparam int unsigned MulW  = DataW + 1;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned CW    = ProdW - 8;   // Q24.32 partial sums
  localparam int unsigned MagW  = CW - 1;
  localparam int unsigned HiW   = MagW - DataW;
  localparam int unsigned MW    = ProdW - 8;
  localparam int unsigned RW    = MW + 1 - 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_KP,
    ST_PROP,
    ST_PRELOAD,
    ST_RAW,
    ST_MUL_AW,
    ST_SUM,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_UPDATE,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [DataW-1:0] kp_q, ki_q, kaw_q, period_q;
  logic [LimW-1:0]  lim_q;

  // controller state and per-request working registers
  logic signed [DataW-1:0] integ_q;
  logic [ModeW-1:0]        mode_q;
  logic signed [DataW-1:0] err_q, prop_q, raw_q, cmd_q, pre_q;
  logic                    limited_q, ovf_q;
  logic signed [CW-1:0]    ci_q;
  logic                    neg_q;
  logic [MagW-1:0]         mag_q;
  logic [DataW-1:0]        lo_q;

  // result register
  logic                    out_valid_q;
  logic signed [DataW-1:0] o_err_q, o_prop_q, o_raw_q, o_cmd_q, o_integ_q;
  logic                    o_limited_q, o_ovf_q;

  // shared multiplier
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod_d, prod_q;

  logic in_take, cfg_take, out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_take    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // ---- datapath around the multiplier ----
  logic signed [WideW-1:0] err_wide;
  logic signed [ProdW:0]   prop_sum;
  logic signed [ProdW-24:0] prop_wide;
  logic signed [WideW-1:0] raw_wide, pre_wide, upd_wide;
  logic signed [DataW-1:0] raw_sat, cmd_val;
  logic signed [MulW-1:0]  diff;
  logic signed [CW-1:0]    ca, c_sum, c_abs;
  logic [MW-1:0]           m_sum;
  logic [MW:0]             rnd;
  logic [RW-1:0]           r_mag;
  logic signed [RW:0]      delta;
  logic [LimW-1:0]         cfg_lim;

  assign err_wide  = WideW'(speed_target_i) - WideW'(speed_measured_i);
  assign prop_sum  = (ProdW+1)'(prod_q) + ((ProdW+1)'(1) <<< 23);
  assign prop_wide = prop_sum[ProdW:24];
  assign raw_wide  = WideW'(prop_q) + WideW'(integ_q);
  assign raw_sat   = sat32(raw_wide);
  assign cmd_val   = clamp_lim(WideW'(raw_sat), lim_q);
  assign pre_wide  = WideW'(pre_q) - WideW'(prop_q);
  assign diff      = MulW'(cmd_q) - MulW'(raw_q);
  assign ca        = prod_q[ProdW-1:8];
  assign c_sum     = ci_q + ca;
  assign c_abs     = c_sum[CW-1] ? -c_sum : c_sum;
  // hi product plus the carried top half of the lo product
  assign m_sum     = prod_q[MW-1:0] + MW'(lo_q);
  assign rnd       = (MW+1)'(m_sum) + (MW+1)'(32768);
  assign r_mag     = rnd[MW:16];
  assign delta     = neg_q ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
  assign upd_wide  = WideW'(integ_q) + WideW'(delta);
  assign cfg_lim   = cfg_data_i[LimW-1:0];

  always_comb begin
    unique case (state_q)
      ST_MUL_KP: begin
        mul_a = $signed({1'b0, kp_q});
        mul_b = MulW'(err_q);
      end
      ST_PROP: begin
        mul_a = $signed({1'b0, ki_q});
        mul_b = MulW'(err_q);
      end
      ST_MUL_AW: begin
        mul_a = $signed({1'b0, kaw_q});
        mul_b = diff;
      end
      ST_MUL_LO: begin
        mul_a = $signed({1'b0, mag_q[DataW-1:0]});
        mul_b = $signed({1'b0, period_q});
      end
      ST_MUL_HI: begin
        mul_a = $signed({{(MulW-HiW){1'b0}}, mag_q[MagW-1:DataW]});
        mul_b = $signed({1'b0, period_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // ---- sequencer, state and registered outputs ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kp_q        <= PROP_GAIN_RST;
      ki_q        <= INTEGRAL_GAIN_RST;
      kaw_q       <= AW_GAIN_RST;
      lim_q       <= CURRENT_LIMIT_RST;
      period_q    <= SAMPLE_PERIOD_RST;
      integ_q     <= '0;
      mode_q      <= MODE_STEP;
      err_q       <= '0;
      prop_q      <= '0;
      raw_q       <= '0;
      cmd_q       <= '0;
      pre_q       <= '0;
      limited_q   <= 1'b0;
      ovf_q       <= 1'b0;
      ci_q        <= '0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      lo_q        <= '0;
      out_valid_q <= 1'b0;
      o_err_q     <= '0;
      o_prop_q    <= '0;
      o_raw_q     <= '0;
      o_cmd_q     <= '0;
      o_integ_q   <= '0;
      o_limited_q <= 1'b0;
      o_ovf_q     <= 1'b0;
    end else begin
      // drop a delivered result
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // configuration writes, only while idle
      if (cfg_take) begin
        unique case (cfg_index_i)
          REG_PROP_GAIN:     kp_q  <= cfg_data_i;
          REG_INTEGRAL_GAIN: ki_q  <= cfg_data_i;
          REG_AW_GAIN:       kaw_q <= cfg_data_i;
          REG_CURRENT_LIMIT: begin
            if (cfg_lim != '0) begin
              lim_q   <= cfg_lim;
              integ_q <= clamp_lim(WideW'(integ_q), cfg_lim);
            end
          end
          REG_SAMPLE_PERIOD: begin
            if (cfg_data_i != '0) begin
              period_q <= cfg_data_i;
            end
          end
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            mode_q    <= mode_i;
            pre_q     <= preload_current_i;
            prop_q    <= '0;
            raw_q     <= '0;
            cmd_q     <= '0;
            limited_q <= 1'b0;
            if (mode_i == MODE_STEP || mode_i == MODE_PRELOAD) begin
              err_q   <= sat32(err_wide);
              ovf_q   <= over32(err_wide);
              state_q <= ST_MUL_KP;
            end else begin
              err_q   <= '0;
              ovf_q   <= 1'b0;
              if (mode_i == MODE_CLEAR) begin
                integ_q <= '0;
              end
              state_q <= ST_DONE;
            end
          end
        end
        ST_MUL_KP: begin
          state_q <= ST_PROP;
        end
        ST_PROP: begin
          prop_q <= sat32(WideW'(prop_wide));
          if (over32(WideW'(prop_wide))) begin
            ovf_q <= 1'b1;
          end
          state_q <= (mode_q == MODE_PRELOAD) ? ST_PRELOAD : ST_RAW;
        end
        ST_PRELOAD: begin
          if (!ovf_q) begin
            integ_q <= clamp_lim(pre_wide, lim_q);
          end
          state_q <= ST_DONE;
        end
        ST_RAW: begin
          raw_q     <= raw_sat;
          cmd_q     <= cmd_val;
          limited_q <= (cmd_val != raw_sat);
          if (over32(raw_wide)) begin
            ovf_q <= 1'b1;
          end
          ci_q    <= prod_q[ProdW-1:8];   // floor(ki*err / 2^8)
          state_q <= ST_MUL_AW;
        end
        ST_MUL_AW: begin
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          neg_q   <= c_sum[CW-1];
          mag_q   <= c_abs[MagW-1:0];
          state_q <= ST_MUL_LO;
        end
        ST_MUL_LO: begin
          state_q <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          lo_q    <= prod_q[2*DataW-1:DataW];
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (!ovf_q) begin
            integ_q <= clamp_lim(upd_wide, lim_q);
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the result register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            o_err_q     <= err_q;
            o_prop_q    <= prop_q;
            o_raw_q     <= raw_q;
            o_cmd_q     <= cmd_q;
            o_limited_q <= limited_q;
            o_integ_q   <= integ_q;
            o_ovf_q     <= ovf_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign speed_error_o     = o_err_q;
  assign prop_term_o       = o_prop_q;
  assign raw_command_o     = o_raw_q;
  assign current_command_o = o_cmd_q;
  assign limited_o         = o_limited_q;
  assign integrator_out_o  = o_integ_q;
  assign overflow_o        = o_ovf_q;

`ifndef SYNTHESIS
  // integrator stays inside the symmetric limit
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($signed({2'b00, lim_q}) >= 33'(integ_q)) && (-$signed({2'b00, lim_q}) <= 33'(integ_q)))
    else $error("integrator outside current limit");

  // sequencer goes busy after taking a request
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_stall_o)
    else $error("request taken but sequencer not busy");

  // clear request zeroes the integrator
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && mode_i == MODE_CLEAR) |=> (integ_q == '0))
    else $error("integrator not cleared");
`endif

endmodule

`default_nettype wire

[verif/speed_pi_back_calc_antiwindup_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// speed_pi_back_calc_antiwindup_unit_test
// Self-checking bench for the fixed-point speed PI controller with
// back-calculation anti-windup. Requests go in through the valid/stall
// channel with random gaps. Results come back with random and long stalls.
// Registers are reprogrammed between phases. A bit-true mirror of the
// controller predicts every result, and a queue checks each result in order.
// ----------------------------------------------------------------------------
module speed_pi_back_calc_antiwindup_unit_test;
  import spaw_pkg::*;

  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned PHASE_ITEMS     = 192;
  localparam int unsigned MAX_REPORTS     = 10;

  // mode code outside the three real operations; the block must ignore it
  localparam logic [ModeW-1:0]   MODE_NOP  = 2'd3;
  // register index past the last real register; writes must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd5;

  localparam longint WORD_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam longint WORD_MIN   = -WORD_MAX - 1;
  localparam longint ROUND_HALF = 64'sd8388608;   // half an LSB of the Q8.24 product

  typedef struct {
    logic [ModeW-1:0]        mode;
    logic signed [DataW-1:0] speed_target;
    logic signed [DataW-1:0] speed_measured;
    logic signed [DataW-1:0] preload_current;
  } pi_request_t;

  typedef struct {
    logic signed [DataW-1:0] speed_error;
    logic signed [DataW-1:0] prop_term;
    logic signed [DataW-1:0] raw_command;
    logic signed [DataW-1:0] current_command;
    logic                    limited;
    logic signed [DataW-1:0] integrator_out;
    logic                    overflow;
  } pi_result_t;

  // --------------------------------------------------------------------------
  // Mirror of the controller: own copy of the registers and the integrator,
  // plus the queue of commands it expects the block to produce.
  // --------------------------------------------------------------------------
  class speed_loop_mirror;
    logic [DataW-1:0] kp;
    logic [DataW-1:0] ki;
    logic [DataW-1:0] kaw;
    logic [LimW-1:0]  limit;
    logic [DataW-1:0] period;
    longint           integ;
    pi_result_t       expected_commands[$];
    int unsigned      n_step, n_preload, n_clear, n_nop;
    int unsigned      n_clamped, n_overflow, n_checked, n_errors;

    function new();
      kp     = PROP_GAIN_RST;
      ki     = INTEGRAL_GAIN_RST;
      kaw    = AW_GAIN_RST;
      limit  = CURRENT_LIMIT_RST;
      period = SAMPLE_PERIOD_RST;
      integ  = 0;
    endfunction

    function int unsigned outstanding();
      return expected_commands.size();
    endfunction

    function longint saturate(longint x, inout bit hit);
      if (x > WORD_MAX) begin
        hit = 1'b1;
        return WORD_MAX;
      end
      if (x < WORD_MIN) begin
        hit = 1'b1;
        return WORD_MIN;
      end
      return x;
    endfunction

    function longint clamp_to_limit(longint x);
      longint hi;
      hi = longint'(limit);
      if (x > hi) return hi;
      if (x < -hi) return -hi;
      return x;
    endfunction

    // c * T / 2^48, magnitude rounded half away from zero
    function longint scale_by_period(longint c);
      bit                neg;
      longint unsigned   mag, lo, hi, m, r;
      neg = (c < 0);
      mag = neg ? longint'(-c) : c;
      lo  = (mag & 64'hFFFF_FFFF) * period;
      hi  = (mag >> 32) * period;
      m   = hi + (lo >> 32);
      r   = (m + 64'd32768) >> 16;
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function void apply_write(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] value);
      case (idx)
        REG_PROP_GAIN:     kp  = value;
        REG_INTEGRAL_GAIN: ki  = value;
        REG_AW_GAIN:       kaw = value;
        REG_CURRENT_LIMIT: begin
          // drop a zero limit; a new limit clamps the stored integrator at once
          if (value[LimW-1:0] != '0) begin
            limit = value[LimW-1:0];
            integ = clamp_to_limit(integ);
          end
        end
        REG_SAMPLE_PERIOD: begin
          if (value != '0) period = value;
        end
        default: ;
      endcase
    endfunction

    function pi_result_t predict_command(pi_request_t rq);
      pi_result_t res;
      longint     err, prop, raw, cmd, ci, ca, nxt;
      bit         ovf;
      res  = '{default: '0};
      ovf  = 1'b0;
      err  = 0;
      prop = 0;
      if (rq.mode == MODE_STEP || rq.mode == MODE_PRELOAD) begin
        err  = saturate(longint'(rq.speed_target) - longint'(rq.speed_measured), ovf);
        prop = saturate((longint'(kp) * err + ROUND_HALF) >>> 24, ovf);
      end
      case (rq.mode)
        MODE_STEP: begin
          n_step++;
          raw = saturate(prop + integ, ovf);
          cmd = clamp_to_limit(raw);
          // integral push plus the back-calculation pull, both Q24.32
          ci  = (longint'(ki) * err) >>> 8;
          ca  = (longint'(kaw) * (cmd - raw)) >>> 8;
          nxt = clamp_to_limit(integ + scale_by_period(ci + ca));
          if (!ovf) integ = nxt;
          res.speed_error     = err[DataW-1:0];
          res.prop_term       = prop[DataW-1:0];
          res.raw_command     = raw[DataW-1:0];
          res.current_command = cmd[DataW-1:0];
          res.limited         = (cmd != raw);
        end
        MODE_PRELOAD: begin
          n_preload++;
          nxt = clamp_to_limit(longint'(rq.preload_current) - prop);
          if (!ovf) integ = nxt;
          res.speed_error = err[DataW-1:0];
          res.prop_term   = prop[DataW-1:0];
        end
        MODE_CLEAR: begin
          n_clear++;
          integ = 0;
        end
        default: n_nop++;
      endcase
      res.integrator_out = integ[DataW-1:0];
      res.overflow       = ovf;
      if (res.limited) n_clamped++;
      if (ovf) n_overflow++;
      return res;
    endfunction

    function void note_request(pi_request_t rq);
      expected_commands.push_back(predict_command(rq));
    endfunction

    function void flag_failure(string msg);
      n_errors++;
      if (n_errors <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
    endfunction

    function void compare_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (got !== want) begin
        flag_failure($sformatf("result %0d %s: expected %0d (0x%h) got %0d (0x%h)",
                               n_checked, field, $signed(want), want, $signed(got), got));
      end
    endfunction

    function void check_command(pi_result_t got);
      pi_result_t want;
      if (expected_commands.size() == 0) begin
        flag_failure("result with no request pending");
        return;
      end
      want = expected_commands.pop_front();
      compare_field("speed_error", want.speed_error, got.speed_error);
      compare_field("prop_term", want.prop_term, got.prop_term);
      compare_field("raw_command", want.raw_command, got.raw_command);
      compare_field("current_command", want.current_command, got.current_command);
      compare_field("limited", want.limited, got.limited);
      compare_field("integrator_out", want.integrator_out, got.integrator_out);
      compare_field("overflow", want.overflow, got.overflow);
      n_checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, ports and the block
  // --------------------------------------------------------------------------
  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [ModeW-1:0]          mode_i;
  logic signed [DataW-1:0]   speed_target_i;
  logic signed [DataW-1:0]   speed_measured_i;
  logic signed [DataW-1:0]   preload_current_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [DataW-1:0]   speed_error_o;
  logic signed [DataW-1:0]   prop_term_o;
  logic signed [DataW-1:0]   raw_command_o;
  logic signed [DataW-1:0]   current_command_o;
  logic                      limited_o;
  logic signed [DataW-1:0]   integrator_out_o;
  logic                      overflow_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [DataW-1:0]          cfg_data_i;

  speed_loop_mirror mirror = new();

  // idling knobs: a calm side never idles; the hold-off request makes the
  // result side stall for a long stretch
  bit                      calm_tx;
  bit                      calm_rx;
  bit                      hold_off_pending;
  int unsigned             settings_used;
  logic signed [DataW-1:0] burst_target;
  int unsigned             burst_left;
  int unsigned             burst_shift;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  speed_pi_back_calc_antiwindup_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .speed_target_i    (speed_target_i),
    .speed_measured_i  (speed_measured_i),
    .preload_current_i (preload_current_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .speed_error_o     (speed_error_o),
    .prop_term_o       (prop_term_o),
    .raw_command_o     (raw_command_o),
    .current_command_o (current_command_o),
    .limited_o         (limited_o),
    .integrator_out_o  (integrator_out_o),
    .overflow_o        (overflow_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DataW-1:0] random_speed();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $urandom;
      default: return int'($urandom) >>> $urandom_range(6, 20);
    endcase
  endfunction

  // flavor 0: upper extremes, flavor 1: lower extremes, else random
  function automatic logic [DataW-1:0] random_setting(input logic [CfgIdxW-1:0] idx,
                                                      input int unsigned flavor);
    case (idx)
      REG_CURRENT_LIMIT: begin
        if (flavor == 0) return 32'h7FFF_FFFF;
        if (flavor == 1) return 32'd1;
        case ($urandom_range(0, 4))
          0:       return 32'd1;
          1:       return 32'h7FFF_FFFF;
          2, 3:    return $urandom_range(32'h0001_0000, 32'h0040_0000);
          default: return $urandom;   // top bit set or a zero get exercised here
        endcase
      end
      REG_SAMPLE_PERIOD: begin
        if (flavor == 0) return 32'hFFFF_FFFF;
        if (flavor == 1) return 32'd1;
        case ($urandom_range(0, 4))
          0:       return 32'd1;
          1:       return 32'hFFFF_FFFF;
          2, 3:    return $urandom_range(32'd429497, 32'd42949673);
          default: return $urandom;
        endcase
      end
      default: begin
        if (flavor == 0) return 32'hFFFF_FFFF;
        if (flavor == 1) return 32'd0;
        case ($urandom_range(0, 4))
          0:       return 32'd0;
          1:       return 32'hFFFF_FFFF;
          2:       return $urandom_range(0, 32'h0100_0000);
          3:       return $urandom_range(0, 32'h1000_0000);
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Most requests follow a setpoint held for a burst, with the measured speed
  // scattered around it, so the integrator winds up and the clamp engages.
  // The rest is noise over the whole field range.
  function automatic pi_request_t random_request();
    pi_request_t rq;
    int unsigned r;
    if (burst_left == 0) begin
      burst_target = random_speed();
      burst_shift  = $urandom_range(8, 26);
      burst_left   = $urandom_range(8, 32);
    end
    burst_left--;
    r = $urandom_range(0, 99);
    rq.preload_current = int'($urandom) >>> $urandom_range(0, 16);
    if (r < 85) begin
      rq.mode           = (r < 76) ? MODE_STEP : (r < 81) ? MODE_PRELOAD : MODE_CLEAR;
      rq.speed_target   = burst_target;
      rq.speed_measured = burst_target - (int'($urandom) >>> burst_shift);
    end else begin
      rq.mode           = ($urandom_range(0, 19) == 0) ? MODE_NOP : ModeW'($urandom_range(0, 2));
      rq.speed_target   = $urandom;
      rq.speed_measured = $urandom;
    end
    return rq;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers: every change lands on a falling edge
  // --------------------------------------------------------------------------

  // Offer one request, hold it until it is taken, note it in the mirror.
  // Drop valid right after the request is taken, so the block never sees it
  // twice; the sequencer is busy for at least that long anyway.
  task automatic offer(input logic [ModeW-1:0] mode, input logic signed [DataW-1:0] tgt,
                       input logic signed [DataW-1:0] meas,
                       input logic signed [DataW-1:0] pc);
    pi_request_t rq;
    int unsigned gap;
    rq.mode            = mode;
    rq.speed_target    = tgt;
    rq.speed_measured  = meas;
    rq.preload_current = pc;
    gap = calm_tx ? 0 : idle_length();
    repeat (gap) @(negedge clk_i);
    in_valid_i        <= 1'b1;
    mode_i            <= mode;
    speed_target_i    <= tgt;
    speed_measured_i  <= meas;
    preload_current_i <= pc;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    mirror.note_request(rq);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write one register; valid is left high for a following write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    mirror.apply_write(idx, value);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input int unsigned flavor);
    logic [CfgIdxW-1:0] idx;
    for (int k = REG_PROP_GAIN; k <= REG_SAMPLE_PERIOD; k++) begin
      idx = CfgIdxW'(k);
      write_reg(idx, random_setting(idx, flavor));
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Wait until every expected result is back, then let the sequencer go idle.
  task automatic settle();
    while (mirror.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, long hold-off on request, in-order check
  // --------------------------------------------------------------------------
  initial begin : result_stall
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall_left       = HOLD_OFF_CYCLES;
      end
      if (stall_left == 0 && !calm_rx) stall_left = idle_length();
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    pi_result_t seen;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      seen.speed_error     = speed_error_o;
      seen.prop_term       = prop_term_o;
      seen.raw_command     = raw_command_o;
      seen.current_command = current_command_o;
      seen.limited         = limited_o;
      seen.integrator_out  = integrator_out_o;
      seen.overflow        = overflow_o;
      mirror.check_command(seen);
    end
  end

  // Watchdog: end the run when no channel moves anything for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni !== 1'b1 || (in_valid_i && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && !out_stall_i) || (cfg_valid_i && cfg_ready_o === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[%0t] watchdog: no transfer for %0d cycles, %0d results still pending",
             $time, STALL_LIMIT, mirror.outstanding());
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    pi_request_t rq;
    int unsigned flavor;
    in_valid_i        = 1'b0;
    mode_i            = MODE_STEP;
    speed_target_i    = '0;
    speed_measured_i  = '0;
    preload_current_i = '0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = REG_PROP_GAIN;
    cfg_data_i        = '0;
    calm_tx           = 1'b0;
    calm_rx           = 1'b0;
    hold_off_pending  = 1'b0;
    settings_used     = 0;
    burst_left        = 0;
    rst_ni            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: zero gains, so only the speed error shows.
    offer(MODE_STEP, 32'sd65536000, 32'sd0, 32'sd0);

    // Upper extremes of every register; drive the error and prop saturations.
    settle();
    program_regs(0);
    offer(MODE_STEP, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
    offer(MODE_STEP, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0);
    offer(MODE_STEP, 32'sd0, 32'sd0, 32'sd0);
    offer(MODE_STEP, 32'sd65536, 32'sd0, 32'sd0);
    offer(MODE_STEP, -32'sd1, 32'sd0, 32'sd0);
    offer(MODE_PRELOAD, 32'sd0, 32'sd0, 32'sh7FFF_FFFF);
    offer(MODE_PRELOAD, 32'sd5, 32'sd3, 32'sh8000_0000);
    // preload with a saturated error keeps the integrator
    offer(MODE_PRELOAD, 32'sh8000_0000, 32'sd1, 32'sd12345);
    // prop overflows on its own
    offer(MODE_STEP, 32'sh4000_0000, 32'sd0, 32'sd0);
    offer(MODE_CLEAR, 32'sh1234_5678, -32'sd99, 32'sd777);
    offer(MODE_NOP, 32'sh7FFF_FFFF, 32'sd0, 32'sh7FFF_FFFF);

    // Unity kp, tight 1 A limit: wind the integrator into the clamp both ways.
    settle();
    write_reg(REG_PROP_GAIN, 32'h0100_0000);
    write_reg(REG_INTEGRAL_GAIN, 32'h0010_0000);
    write_reg(REG_AW_GAIN, 32'h0200_0000);
    write_reg(REG_CURRENT_LIMIT, 32'h0001_0000);
    write_reg(REG_SAMPLE_PERIOD, 32'd429497);
    cfg_valid_i <= 1'b0;
    settings_used++;
    offer(MODE_PRELOAD, 32'sd0, 32'sd0, 32'sh7FFF_FFFF);
    offer(MODE_STEP, 32'sd655360, 32'sd0, 32'sd0);
    offer(MODE_STEP, -32'sd655360, 32'sd0, 32'sd0);

    // Zero limit, zero period and an unused index must all be dropped.
    settle();
    write_reg(REG_CURRENT_LIMIT, 32'd0);
    write_reg(REG_SAMPLE_PERIOD, 32'd0);
    write_reg(REG_SPARE, 32'd123);
    cfg_valid_i <= 1'b0;
    offer(MODE_STEP, 32'sd1000, 32'sd999, 32'sd0);
    offer(MODE_PRELOAD, 32'sd42, 32'sd42, 32'sd32768);

    // Shrinking the limit below the stored integrator clamps it right away.
    settle();
    write_reg(REG_CURRENT_LIMIT, 32'h0000_4000);
    cfg_valid_i <= 1'b0;
    offer(MODE_NOP, 32'sd0, 32'sd0, 32'sd0);
    offer(MODE_STEP, 32'sd0, 32'sd0, 32'sd0);
    in_valid_i <= 1'b0;

    // Random phases, each under its own register setting. One phase keeps the
    // sender busy while the result side holds off, so the block backs up.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      flavor = (ph < 2) ? ph : 2;
      program_regs(flavor);
      calm_tx = ($urandom_range(0, 3) == 0);
      calm_rx = ($urandom_range(0, 3) == 0);
      if (ph == 4) begin
        calm_tx          = 1'b1;
        hold_off_pending = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rq = random_request();
        offer(rq.mode, rq.speed_target, rq.speed_measured, rq.preload_current);
      end
      in_valid_i <= 1'b0;
    end

    settle();
    $display("Covered %0d control steps, %0d preloads, %0d clears and %0d ignored-mode requests",
             mirror.n_step, mirror.n_preload, mirror.n_clear, mirror.n_nop);
    $display("over %0d register settings; %0d results checked, %0d clamped,",
             settings_used, mirror.n_checked, mirror.n_clamped);
    $display("%0d overflowed, %0d mismatches", mirror.n_overflow, mirror.n_errors);
    if (mirror.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
